### rtl/kth_smallest_select_defines.svh
// Assertion macros shared by the checker of the rank selection block.
// Depends on nothing; every user must have clk and arst_n in scope.
`ifndef KTH_SMALLEST_SELECT_DEFINES_SVH
`define KTH_SMALLEST_SELECT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSEL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ksel_pkg.sv
// Shared constants, beat types and controller/datapath interface structs
// for the rank selection block. Depends on nothing.
package ksel_pkg;

	// Store geometry and derived widths.
	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int RANK_W  = 10;
	localparam int DATA_W  = 32;
	localparam int CUR_W   = ((CNT_W > RANK_W) ? CNT_W : RANK_W) + 1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [CUR_W-1:0]  cur_t;
	typedef logic [RANK_W-1:0]        rank_t;

	// Read address sources of the element store.
	localparam int RD_W = 3;
	localparam logic [RD_W-1:0] RD_RANK      = 3'd0;
	localparam logic [RD_W-1:0] RD_LOWER     = 3'd1;
	localparam logic [RD_W-1:0] RD_LEFT_INC  = 3'd2;
	localparam logic [RD_W-1:0] RD_RIGHT     = 3'd3;
	localparam logic [RD_W-1:0] RD_RIGHT_DEC = 3'd4;

	// Input and output beats.
	typedef struct packed {
		logic signed [DATA_W-1:0] sample_value;
		logic                     is_last;
	} in_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] ranked_value;
		logic                     rank_error;
	} out_beat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            load;
		logic            res_err;
		logic            res_ld;
		logic            pivot_ld;
		logic            left_inc;
		logic            right_dec;
		logic            lval_ld;
		logic            rval_ld;
		logic            wr_left;
		logic            wr_right;
		logic            bound_upd;
		logic [RD_W-1:0] rd_sel;
	} ksel_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rank_oob;
		logic win_open;
		logic lscan_go;
		logic rscan_go;
		logic swap_ok;
		logic cont_ok;
	} ksel_sts_t;

endpackage

### rtl/kth_smallest_select.sv
// Top level of the rank selection block: joins the controller and the
// datapath. Depends on ksel_pkg, ksel_ctrl and ksel_dp.
//
//   Channel   Direction  Handshake          Beat
//   in        sink       in_valid/in_stall  sample_value, is_last
//   out       source     out_valid/out_stall ranked_value, rank_error
//   cfg       sink       cfg_we             select_rank (cfg_wdata)
//
// Loading takes one beat per cycle, save that a closing beat stalls while the
// previous result waits; a result beat may wait at the output while the next
// vector loads. After the closing beat the input stalls while the selection
// runs; each cursor step, swap round and partition pass is paced by the store's
// single read port with registered data, and the result is registered with its
// valid flag after the last pass. A rank at or beyond the vector length gives
// an error beat on the next cycle; reset clears the control state only.
module kth_smallest_select (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  ksel_pkg::rank_t     cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  ksel_pkg::in_beat_t  in_beat,
	output logic                out_valid,
	input  logic                out_stall,
	output ksel_pkg::out_beat_t out_beat
);

	ksel_pkg::ksel_cmd_t cmd;
	ksel_pkg::ksel_sts_t sts;

	// Sequencing of loading and partitioning.
	ksel_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_is_last (in_beat.is_last),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Store, cursors and result register.
	ksel_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_beat   (in_beat),
		.cmd       (cmd),
		.sts       (sts),
		.out_beat  (out_beat)
	);

endmodule

### rtl/ksel_ctrl.sv
// Controller of the rank selection block: loading, partition sequencing and
// output handshake. Depends on ksel_pkg.
module ksel_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_is_last,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  ksel_pkg::ksel_sts_t sts,
	output ksel_pkg::ksel_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_OUTER = 4'd1;
	localparam logic [3:0] ST_PIV   = 4'd2;
	localparam logic [3:0] ST_LCHK  = 4'd3;
	localparam logic [3:0] ST_RCHK  = 4'd4;
	localparam logic [3:0] ST_SWAP  = 4'd5;
	localparam logic [3:0] ST_SWAP2 = 4'd6;
	localparam logic [3:0] ST_END   = 4'd7;
	localparam logic [3:0] ST_FIN   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	// Next state and command decode.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = ksel_pkg::RD_RANK;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				// A closing beat waits until the previous result has left.
				in_stall = in_is_last && out_valid_q;
				if (in_valid && !in_stall) begin
					cmd.load = 1'b1;
					if (in_is_last) begin
						if (sts.rank_oob) begin
							cmd.res_err = 1'b1;
						end else begin
							state_d = ST_OUTER;
						end
					end
				end
			end
			ST_OUTER: begin
				cmd.rd_sel = ksel_pkg::RD_RANK;
				state_d    = sts.win_open ? ST_PIV : ST_FIN;
			end
			ST_PIV: begin
				cmd.pivot_ld = 1'b1;
				cmd.rd_sel   = ksel_pkg::RD_LOWER;
				state_d      = ST_LCHK;
			end
			ST_LCHK: begin
				if (sts.lscan_go) begin
					cmd.left_inc = 1'b1;
					cmd.rd_sel   = ksel_pkg::RD_LEFT_INC;
				end else begin
					cmd.lval_ld = 1'b1;
					cmd.rd_sel  = ksel_pkg::RD_RIGHT;
					state_d     = ST_RCHK;
				end
			end
			ST_RCHK: begin
				if (sts.rscan_go) begin
					cmd.right_dec = 1'b1;
					cmd.rd_sel    = ksel_pkg::RD_RIGHT_DEC;
				end else begin
					cmd.rval_ld = 1'b1;
					state_d     = ST_SWAP;
				end
			end
			ST_SWAP: begin
				if (sts.swap_ok) begin
					cmd.wr_left = 1'b1;
					state_d     = ST_SWAP2;
				end else begin
					state_d = ST_END;
				end
			end
			ST_SWAP2: begin
				cmd.wr_right = 1'b1;
				cmd.rd_sel   = ksel_pkg::RD_LEFT_INC;
				state_d      = sts.cont_ok ? ST_LCHK : ST_END;
			end
			ST_END: begin
				cmd.bound_upd = 1'b1;
				state_d       = ST_OUTER;
			end
			ST_FIN: begin
				cmd.res_ld = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_ld || cmd.res_err) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/ksel_dp.sv
// Datapath of the rank selection block: element store, cursors, bounds,
// pivot, comparators and the result register. Depends on ksel_pkg.
module ksel_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  ksel_pkg::rank_t        cfg_wdata,
	input  ksel_pkg::in_beat_t     in_beat,
	input  ksel_pkg::ksel_cmd_t    cmd,
	output ksel_pkg::ksel_sts_t    sts,
	output ksel_pkg::out_beat_t    out_beat
);

	localparam int AW = ksel_pkg::ADDR_W;
	localparam int CW = ksel_pkg::CNT_W;
	localparam int UW = ksel_pkg::CUR_W;
	localparam int RW = ksel_pkg::RANK_W;

	ksel_pkg::data_t     store_mem [ksel_pkg::MAX_LEN];
	ksel_pkg::data_t     rdata_q;
	ksel_pkg::data_t     pivot_q;
	ksel_pkg::data_t     lval_q;
	ksel_pkg::data_t     rval_q;
	ksel_pkg::rank_t     rank_q;
	logic [CW-1:0]       count_q;
	ksel_pkg::cur_t      lenm1_q;
	ksel_pkg::cur_t      lower_q;
	ksel_pkg::cur_t      upper_q;
	ksel_pkg::cur_t      left_q;
	ksel_pkg::cur_t      right_q;
	ksel_pkg::out_beat_t res_q;

	logic                count_full;
	logic [CW-1:0]       len_next;
	ksel_pkg::cur_t      len_c;
	ksel_pkg::cur_t      rank_c;
	ksel_pkg::cur_t      left_p1;
	ksel_pkg::cur_t      right_m1;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	ksel_pkg::data_t     wdata;
	logic                mem_we;

	// Length the vector would have if the current beat closed it.
	assign count_full = (count_q >= CW'(ksel_pkg::MAX_LEN));
	assign len_next   = count_full ? count_q : count_q + CW'(1);
	assign len_c      = ksel_pkg::cur_t'({{(UW - CW){1'b0}}, len_next});
	assign rank_c     = ksel_pkg::cur_t'({{(UW - RW){1'b0}}, rank_q});
	assign left_p1    = left_q + ksel_pkg::cur_t'(1);
	assign right_m1   = right_q - ksel_pkg::cur_t'(1);

	// Status towards the controller.
	always_comb begin
		sts.rank_oob = (rank_c >= len_c);
		sts.win_open = (lower_q < upper_q);
		sts.lscan_go = (left_q < lenm1_q) && (rdata_q < pivot_q);
		sts.rscan_go = (right_q > ksel_pkg::cur_t'(0)) && (pivot_q < rdata_q);
		sts.swap_ok  = (left_q <= right_q);
		sts.cont_ok  = (left_q + ksel_pkg::cur_t'(2)) <= right_q;
	end

	// Read address selection.
	always_comb begin
		unique case (cmd.rd_sel)
			ksel_pkg::RD_RANK:      raddr = rank_c[AW-1:0];
			ksel_pkg::RD_LOWER:     raddr = lower_q[AW-1:0];
			ksel_pkg::RD_LEFT_INC:  raddr = left_p1[AW-1:0];
			ksel_pkg::RD_RIGHT:     raddr = right_q[AW-1:0];
			ksel_pkg::RD_RIGHT_DEC: raddr = right_m1[AW-1:0];
			default:                raddr = rank_c[AW-1:0];
		endcase
	end

	// Write port: loading, then the two halves of a swap.
	always_comb begin
		mem_we = 1'b0;
		waddr  = count_q[AW-1:0];
		wdata  = in_beat.sample_value;
		if (cmd.load) begin
			mem_we = !count_full;
		end else if (cmd.wr_left) begin
			mem_we = 1'b1;
			waddr  = left_q[AW-1:0];
			wdata  = rval_q;
		end else if (cmd.wr_right) begin
			mem_we = 1'b1;
			waddr  = right_q[AW-1:0];
			wdata  = lval_q;
		end
	end

	// Element store with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[waddr] <= wdata;
		end
		rdata_q <= store_mem[raddr];
	end

	// Element payload registers.
	always_ff @(posedge clk) begin
		if (cmd.pivot_ld) begin
			pivot_q <= rdata_q;
		end
		if (cmd.lval_ld) begin
			lval_q <= rdata_q;
		end
		if (cmd.rval_ld) begin
			rval_q <= rdata_q;
		end
		if (cmd.res_err) begin
			res_q.ranked_value <= '0;
			res_q.rank_error   <= 1'b1;
		end else if (cmd.res_ld) begin
			res_q.ranked_value <= rdata_q;
			res_q.rank_error   <= 1'b0;
		end
	end

	// Rank register, fill count, window bounds and cursors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q  <= '0;
			count_q <= '0;
			lenm1_q <= '0;
			lower_q <= '0;
			upper_q <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			if (cfg_we) begin
				rank_q <= cfg_wdata;
			end
			if (cmd.load) begin
				if (in_beat.is_last) begin
					count_q <= '0;
					lenm1_q <= len_c - ksel_pkg::cur_t'(1);
					lower_q <= '0;
					upper_q <= len_c - ksel_pkg::cur_t'(1);
				end else begin
					count_q <= len_next;
				end
			end
			if (cmd.pivot_ld) begin
				left_q  <= lower_q;
				right_q <= upper_q;
			end
			if (cmd.left_inc || cmd.wr_right) begin
				left_q <= left_p1;
			end
			if (cmd.right_dec || cmd.wr_right) begin
				right_q <= right_m1;
			end
			if (cmd.bound_upd) begin
				if (right_q < rank_c) begin
					lower_q <= left_q;
				end
				if (rank_c < left_q) begin
					upper_q <= right_q;
				end
			end
		end
	end

	assign out_beat = res_q;

endmodule

### rtl/ksel_chk.sv
// Port-level checker for the rank selection block, bound to the top level.
// Depends on ksel_pkg and kth_smallest_select_defines.svh.
`include "kth_smallest_select_defines.svh"

module ksel_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input ksel_pkg::in_beat_t  in_beat,
	input logic                out_valid,
	input logic                out_stall,
	input ksel_pkg::out_beat_t out_beat
);

	// A stalled result beat stays offered and unchanged.
	`KSEL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat), "result beat changed while stalled")

	// An error beat carries a zero value.
	`KSEL_ASSERT_NOW(a_err_zero, out_valid && out_beat.rank_error, out_beat.ranked_value == '0, "error beat with non-zero value")

	// A closing beat is held off while the previous result is still waiting.
	`KSEL_ASSERT_NOW(a_last_blocked, in_valid && in_beat.is_last && out_valid, in_stall, "closing beat taken over a pending result")

	// After a closing beat either the selection runs or the error beat shows.
	`KSEL_ASSERT_NEXT(a_last_then, in_valid && !in_stall && in_beat.is_last, out_valid || in_stall, "input not held after closing beat")

endmodule

bind kth_smallest_select ksel_chk u_ksel_chk (.*);
